[hdl/lrukv_pkg.sv]
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
package lrukv_pkg;

  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RESP
  } state_e;

endpackage

[hdl/lrukv_dir.sv]
// Key directory: keys, valid marks, recency ranks, fill count and lookup.
`timescale 1ns / 1ps
module lrukv_dir import lrukv_pkg::*; #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16,
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned FILL_W  = $clog2(ENTRIES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CAP_BITS-1:0] cap_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic                put_i,
  input  logic                update_i,
  output logic                hit_o,
  output logic [IDX_W-1:0]    rd_idx_o,
  output logic [IDX_W-1:0]    wr_idx_o
);

  logic [KEY_BITS-1:0] key_q  [ENTRIES];
  logic [IDX_W-1:0]    rank_q [ENTRIES];
  logic [IDX_W-1:0]    rank_d [ENTRIES];
  logic [ENTRIES-1:0]  valid_q, valid_d, match;
  logic [FILL_W-1:0]   fill_q, fill_d;

  logic             hit, full, victim_ok;
  logic [IDX_W-1:0] hit_idx, victim_idx, free_idx, slot, s;
  logic [IDX_W:0]   old_rank;
  logic [31:0]      eff_cap;

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    victim_ok  = 1'b0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (key_q[i] == key_i);
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      // oldest valid entry carries rank fill - 1
      if (valid_q[i] && ({{(32-IDX_W){1'b0}}, rank_q[i]} == 32'(fill_q) - 32'd1)) begin
        victim_ok  = 1'b1;
        victim_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    if (cap_i == '0) begin
      eff_cap = 32'd1;
    end else if (32'(cap_i) > ENTRIES) begin
      eff_cap = ENTRIES;
    end else begin
      eff_cap = 32'(cap_i);
    end
    full = (32'(fill_q) >= eff_cap);
    slot = full ? victim_idx : free_idx;
  end

  assign hit_o    = hit;
  assign rd_idx_o = hit_idx;
  assign wr_idx_o = hit ? hit_idx : slot;

  always_comb begin
    s        = hit ? hit_idx : slot;
    old_rank = hit ? {1'b0, rank_q[hit_idx]} : (IDX_W + 1)'(ENTRIES);
    valid_d  = valid_q;
    fill_d   = fill_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (update_i && (hit || put_i)) begin
      // age every younger entry, then make the slot most recent
      for (int i = 0; i < ENTRIES; i++) begin
        if ((IDX_W'(i) != s) && valid_q[i] && ({1'b0, rank_q[i]} < old_rank)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      rank_d[s] = '0;
      if (!hit) begin
        valid_d[s] = 1'b1;
        if (!full) begin
          fill_d = fill_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      fill_q  <= fill_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (update_i && put_i && !hit) begin
      key_q[slot] <= key_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= ENTRIES) else $error("fill count above entry count");
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(fill_q)) else $error("fill count off valid marks");
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("key present in two entries");
  a_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && put_i && !hit && full) |-> victim_ok) else $error("no victim found");

endmodule

[hdl/lru_key_value_cache_core.sv]
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement.
// Each input transfer is a get (tuser 0) or a put (tuser 1) with key and
// value in tdata. Each produces exactly one output transfer: tuser is hit
// (key present before the item), tdata is the stored value on a get hit and
// zero otherwise. Keys, valid marks and recency ranks sit in a register-based
// directory searched in parallel; values sit in a synchronous single-port
// memory with a registered read. An item passes through a lookup state,
// which searches and updates the directory and issues the value read or
// write, then a response state, which lands the read data in the output
// register. A new item is taken in the response state when the output
// register is free. The store is empty after reset with no clearing pass.
// Capacity must be written on the cfg channel only while idle; the block
// does not enforce this. Zero acts as one and values above ENTRIES saturate.
module lru_key_value_cache_core import lrukv_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_BITS-1:0] cfg_data_i,     // capacity
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_W-1:0]     s_axis_tdata,   // key, value, zero pad
  input  logic                s_axis_tuser,   // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata,   // data, zero pad
  output logic                m_axis_tuser    // hit
);

  state_e state_q, state_d;

  logic [CAP_BITS-1:0]   cap_q;
  logic                  op_q, hit_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q, rd_q;
  logic [VALUE_BITS-1:0] mem [ENTRIES];

  logic                  out_valid_q, out_hit_q, out_free, in_xfer, load_out;
  logic [VALUE_BITS-1:0] out_data_q;
  logic                  dir_hit;
  logic [IDX_W-1:0]      rd_idx, wr_idx;
  logic                  look;

  assign cfg_ready_o = 1'b1;
  assign look        = (state_q == ST_LOOK);
  assign out_free    = !out_valid_q || m_axis_tready;

  // Take a new item when idle, or while finishing one whose result can land.
  assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == ST_RESP) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_LOOK;
      end
      ST_LOOK: state_d = ST_RESP;
      ST_RESP: begin
        if (load_out) state_d = in_xfer ? ST_LOOK : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the item; capture hit before the directory moves on.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= s_axis_tuser;
      key_q <= s_axis_tdata[KEY_BITS-1:0];
      val_q <= s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
    end
    if (look) hit_q <= dir_hit;
    if (load_out) begin
      out_hit_q  <= hit_q;
      out_data_q <= ((op_q == OP_GET) && hit_q) ? rd_q : '0;
    end
  end

  // Value store: read the hit entry on get, write on put.
  always_ff @(posedge clk_i) begin
    if (look) begin
      if (op_q == OP_PUT) begin
        mem[wr_idx] <= val_q;
      end else begin
        rd_q <= mem[rd_idx];
      end
    end
  end

  lrukv_dir #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cap_i    (cap_q),
    .key_i    (key_q),
    .put_i    (op_q == OP_PUT),
    .update_i (look),
    .hit_o    (dir_hit),
    .rd_idx_o (rd_idx),
    .wr_idx_o (wr_idx)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_LOOK) else $error("accepted item not looked up");
  a_look_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    look |=> state_q == ST_RESP) else $error("lookup not followed by response");
  a_put_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && op_q == OP_PUT) |=> out_data_q == '0) else $error("put returned data");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the LRU key-value cache core.
`timescale 1ns / 1ps
// Drives random and directed get/put transfers into the cache, predicts
// hit and data with a behavioral LRU model in the scoreboard, and compares
// every output transfer in order. Capacity is rewritten between phases while
// the block is idle.
module tb_top;
  import lrukv_pkg::*;

  localparam int ENTRIES = 16;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic        hit;
    logic [31:0] data;
  } lookup_t;

  // Behavioral LRU store; keeps its own copy of entries and capacity.
  class lru_scoreboard;
    logic [15:0] key_q[ENTRIES];
    logic [31:0] val_q[ENTRIES];
    bit          valid_q[ENTRIES];
    int          age_q[ENTRIES];
    int          fill;
    int          cap;
    lookup_t     pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] = 0;
        age_q[i] = 0;
      end
      fill = 0;
      cap = 16;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] c);
      cap = (c == 0) ? 1 : ((c > ENTRIES) ? ENTRIES : c);
    endfunction

    // Age every valid entry younger than old_age, then make s the newest.
    function void touch(int s, int old_age);
      for (int i = 0; i < ENTRIES; i++)
        if (i != s && valid_q[i] && age_q[i] < old_age) age_q[i]++;
      age_q[s] = 0;
    endfunction

    function void note_request(logic op, logic [15:0] k, logic [31:0] v);
      int found;
      int slot;
      int oldest;
      lookup_t r;
      found = -1;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && valid_q[i] && key_q[i] == k) found = i;
      r.hit = (found >= 0);
      r.data = '0;
      if (op == OP_GET) begin
        if (found >= 0) begin
          r.data = val_q[found];
          touch(found, age_q[found]);
        end
      end else if (found >= 0) begin
        val_q[found] = v;
        touch(found, age_q[found]);
      end else begin
        if (fill >= cap) begin
          oldest = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (valid_q[i] && age_q[i] > oldest) begin
              oldest = age_q[i];
              slot = i;
            end
          if (slot >= 0) begin
            valid_q[slot] = 0;
            fill--;
          end
        end
        if (slot < 0)
          for (int i = ENTRIES - 1; i >= 0; i--) if (!valid_q[i]) slot = i;
        if (slot >= 0) begin
          key_q[slot] = k;
          val_q[slot] = v;
          valid_q[slot] = 1;
          touch(slot, ENTRIES);
          fill++;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic hit, logic [31:0] data);
      lookup_t e;
      if (pending.size() == 0) begin
        $error("unexpected result hit=%0d data=%h", hit, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, hit);
        errors++;
      end
      if (data !== e.data) begin
        $error("data: expected %h actual %h", e.data, data);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic [CAP_BITS-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata = '0;   // key, value
  logic                s_axis_tuser = 0;    // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [31:0]         m_axis_tdata;        // data
  logic                m_axis_tuser;        // hit

  lru_scoreboard sb;
  int  idle_cycles;
  bit  rx_quiet;

  lru_key_value_cache_core u_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG) begin
      $display("[lru_key_value_cache_core] ERROR");
      $finish;
    end
  end

  // Receiver: random stall before each result, with occasional quiet runs.
  initial begin
    int gap;
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  task automatic write_capacity(logic [CAP_BITS-1:0] c);
    cfg_valid_i <= 1;
    cfg_data_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.set_capacity(c);
  endtask

  task automatic send_request(logic op, logic [15:0] k, logic [31:0] v, bit nogap);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {v, k};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, k, v);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Narrow key pool so gets hit often and puts replace often.
  function automatic logic [15:0] pick_key(int pool);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom());
    if (r == 1) return 16'hffff - 16'($urandom_range(0, pool));
    return 16'($urandom_range(0, pool));
  endfunction

  initial begin
    logic [CAP_BITS-1:0] caps[6];
    logic [15:0] k;
    bit quiet;
    sb = new();
    sb.clear();
    idle_cycles = 0;
    rx_quiet = 0;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty-store miss, fill, update, extremes, eviction order.
    send_request(OP_GET, 16'h0000, 32'h0, 0);
    send_request(OP_PUT, 16'h0000, 32'hffffffff, 0);
    send_request(OP_PUT, 16'hffff, 32'h00000000, 0);
    send_request(OP_GET, 16'h0000, 32'h12345678, 0);
    send_request(OP_GET, 16'hffff, 32'h0, 0);
    send_request(OP_PUT, 16'h0000, 32'ha5a5a5a5, 0);
    send_request(OP_GET, 16'h0000, 32'h0, 0);
    for (int i = 1; i <= 17; i++) send_request(OP_PUT, 16'(i * 257), 32'(i), 1);
    drain();
    write_capacity(5'd2);
    send_request(OP_PUT, 16'h0bad, 32'h5555aaaa, 0);
    send_request(OP_GET, 16'(17 * 257), 32'h0, 0);
    send_request(OP_GET, 16'h0bad, 32'h0, 0);
    drain();

    // Random phases across capacity settings.
    for (int ph = 0; ph < 12; ph++) begin
      write_capacity(ph < 6 ? caps[ph] : 5'($urandom_range(0, 31)));
      quiet = (ph % 4 == 3);
      rx_quiet = quiet;
      for (int n = 0; n < 160; n++) begin
        k = pick_key(ph % 3 == 0 ? 7 : 31);
        send_request(1'($urandom_range(0, 1)), k, $urandom(), quiet);
      end
      drain();
    end
    rx_quiet = 0;
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[lru_key_value_cache_core] OK");
    end else begin
      $display("[lru_key_value_cache_core] ERROR");
    end
    $finish;
  end

endmodule
